/* rtl/core/can_mailbox_manager_rx_fifo_top_assert.svh */
// Assertion macros for the checker file of the receive FIFO mailbox manager.
`ifndef CAN_MAILBOX_MANAGER_RX_FIFO_TOP_ASSERT_SVH
`define CAN_MAILBOX_MANAGER_RX_FIFO_TOP_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while reset is low.
`define CMM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on aclk, off while reset is low.
`define CMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/cmm_rx_pkg.sv */
package cmm_rx_pkg;

    localparam int OP_W     = 2;
    localparam int ID_W     = 11;
    localparam int DATA_W   = 64;
    localparam int MASK_W   = 15;
    localparam int STATUS_W = 3;
    localparam int MBOX_W   = 4;
    localparam int COUNT_W  = 4;
    localparam int MODE_W   = 2;
    localparam int PICK_IDX_W = 5;

    localparam logic [OP_W-1:0] OP_CLAIM = 2'd0;
    localparam logic [OP_W-1:0] OP_SEND  = 2'd1;
    localparam logic [OP_W-1:0] OP_EVENT = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RX  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TX  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_CLAIMED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RX_QUEUED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RX_DROPPED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TX_RELEASED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NO_FLAG     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_READ_OK     = 3'd6;
    localparam logic [STATUS_W-1:0] ST_READ_EMPTY  = 3'd7;

    typedef struct packed {
        logic                  found;
        logic [PICK_IDX_W-1:0] idx;
    } pick_t;

endpackage

/* rtl/core/cmm_rx_ram.sv */
module cmm_rx_ram #(
    parameter int WIDTH = 75,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/cmm_rx_pick.sv */
module cmm_rx_pick
    import cmm_rx_pkg::*;
#(
    parameter int WIDTH = 15
) (
    input  logic [WIDTH-1:0] req,
    output pick_t            pick
);

    // lowest set request wins
    always_comb begin
        pick = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (req[i]) begin
                pick.found = 1'b1;
                pick.idx   = PICK_IDX_W'(i);
            end
        end
    end

endmodule

/* rtl/core/can_mailbox_manager_rx_fifo_top.sv */
// Channel | Direction | Fields
// s_      | in        | operation, msg_id, payload, rx_done_mask, tx_done_mask
// m_      | out       | status, mailbox, out_id, out_payload, frames_waiting
//
// One item is accepted per cycle unless the m_ side stalls; its result passes
// through one registered pass: input register, mailbox priority pick and FIFO
// RAM port, result register (read data comes from the RAM's own output
// register). Reset is synchronous, active low; it frees all mailboxes and
// empties the FIFO, no clearing pass. A stalled m_ side holds the result and
// backs up into the input register, then drops s_ready.
module can_mailbox_manager_rx_fifo_top
    import cmm_rx_pkg::*;
#(
    parameter int MAILBOXES  = 15,
    parameter int FIFO_DEPTH = 8
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_operation,
    input  logic [ID_W-1:0]     s_msg_id,
    input  logic [DATA_W-1:0]   s_payload,
    input  logic [MASK_W-1:0]   s_rx_done_mask,
    input  logic [MASK_W-1:0]   s_tx_done_mask,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [MBOX_W-1:0]   m_mailbox,
    output logic [ID_W-1:0]     m_out_id,
    output logic [DATA_W-1:0]   m_out_payload,
    output logic [COUNT_W-1:0]  m_frames_waiting
);

    // Event flags only reach the first MASK_W mailboxes.
    localparam int EVT_N     = (MAILBOXES < MASK_W) ? MAILBOXES : MASK_W;
    localparam int MB_IDX_W  = (MAILBOXES > 1) ? $clog2(MAILBOXES) : 1;
    localparam int EVT_IDX_W = (EVT_N > 1) ? $clog2(EVT_N) : 1;
    localparam int PTR_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
    localparam int ENTRY_W   = ID_W + DATA_W;

    // ---------------- input register ----------------
    logic              in_valid_reg;
    logic [OP_W-1:0]   in_op_reg;
    logic [ID_W-1:0]   in_id_reg;
    logic [DATA_W-1:0] in_payload_reg;
    logic [MASK_W-1:0] in_rxm_reg;
    logic [MASK_W-1:0] in_txm_reg;

    // ---------------- state ----------------
    logic [MODE_W-1:0] mode_reg [MAILBOXES];
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;

    // ---------------- result register ----------------
    logic                res_valid_reg;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [MBOX_W-1:0]   res_mbox_reg, res_mbox_next;
    logic [ID_W-1:0]     res_id_reg, res_id_next;
    logic [DATA_W-1:0]   res_payload_reg, res_payload_next;
    logic                res_from_ram_reg, res_from_ram_next;
    logic [COUNT_W-1:0]  res_count_reg;

    logic advance;
    logic work;

    // The pipe moves when the result slot is empty or being taken.
    assign advance = !res_valid_reg || m_ready;
    assign work    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            in_op_reg      <= s_operation;
            in_id_reg      <= s_msg_id;
            in_payload_reg <= s_payload;
            in_rxm_reg     <= s_rx_done_mask;
            in_txm_reg     <= s_tx_done_mask;
        end
    end

    // ---------------- mailbox picks ----------------
    logic [MAILBOXES-1:0] free_vec;
    logic [EVT_N-1:0]     rx_evt;
    logic [EVT_N-1:0]     flag_vec;
    pick_t                free_pick;
    pick_t                flag_pick;

    always_comb begin
        for (int i = 0; i < MAILBOXES; i++) begin
            free_vec[i] = (mode_reg[i] == MODE_OFF);
        end
    end

    // Mask bits beyond the mailbox count are ignored.
    assign rx_evt   = in_rxm_reg[EVT_N-1:0];
    assign flag_vec = rx_evt | in_txm_reg[EVT_N-1:0];

    cmm_rx_pick #(.WIDTH(MAILBOXES)) u_free_pick (
        .req  (free_vec),
        .pick (free_pick)
    );

    cmm_rx_pick #(.WIDTH(EVT_N)) u_flag_pick (
        .req  (flag_vec),
        .pick (flag_pick)
    );

    // ---------------- receive FIFO storage ----------------
    logic              ram_we;
    logic              ram_re;
    logic [ENTRY_W-1:0] ram_rdata;

    cmm_rx_ram #(.WIDTH(ENTRY_W), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata ({in_id_reg, in_payload_reg}),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // ---------------- one pass per item ----------------
    logic                mode_we;
    logic [MB_IDX_W-1:0] mode_widx;
    logic [MODE_W-1:0]   mode_wval;
    logic                fifo_full;
    logic                fifo_empty;

    assign fifo_full  = (fill_reg == CNT_W'(FIFO_DEPTH));
    assign fifo_empty = (fill_reg == '0);

    always_comb begin
        mode_we           = 1'b0;
        mode_widx         = free_pick.idx[MB_IDX_W-1:0];
        mode_wval         = MODE_OFF;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        rd_ptr_next       = rd_ptr_reg;
        wr_ptr_next       = wr_ptr_reg;
        fill_next         = fill_reg;
        res_status_next   = ST_NO_FREE;
        res_mbox_next     = '0;
        res_id_next       = '0;
        res_payload_next  = '0;
        res_from_ram_next = 1'b0;

        unique case (in_op_reg)
            OP_CLAIM, OP_SEND: begin
                if (free_pick.found) begin
                    mode_we         = work;
                    mode_wval       = (in_op_reg == OP_SEND) ? MODE_TX : MODE_RX;
                    res_status_next = ST_CLAIMED;
                    res_mbox_next   = MBOX_W'(free_pick.idx);
                    res_id_next     = in_id_reg;
                    if (in_op_reg == OP_SEND) begin
                        res_payload_next = in_payload_reg;
                    end
                end
            end
            OP_EVENT: begin
                res_status_next = ST_NO_FLAG;
                if (flag_pick.found) begin
                    mode_we       = work;
                    mode_widx     = MB_IDX_W'(flag_pick.idx[EVT_IDX_W-1:0]);
                    res_mbox_next = MBOX_W'(flag_pick.idx);
                    // receive-done wins over transmit-done in the same mailbox
                    if (rx_evt[flag_pick.idx[EVT_IDX_W-1:0]]) begin
                        mode_wval = MODE_RX;
                        if (fifo_full) begin
                            res_status_next = ST_RX_DROPPED;
                        end else begin
                            ram_we          = work;
                            wr_ptr_next     = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1))
                                              ? '0 : wr_ptr_reg + 1'b1;
                            fill_next       = fill_reg + 1'b1;
                            res_status_next = ST_RX_QUEUED;
                        end
                    end else begin
                        mode_wval       = MODE_OFF;
                        res_status_next = ST_TX_RELEASED;
                    end
                end
            end
            OP_READ: begin
                if (fifo_empty) begin
                    res_status_next = ST_READ_EMPTY;
                end else begin
                    ram_re            = work;
                    rd_ptr_next       = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1))
                                        ? '0 : rd_ptr_reg + 1'b1;
                    fill_next         = fill_reg - 1'b1;
                    res_status_next   = ST_READ_OK;
                    res_from_ram_next = 1'b1;
                end
            end
            default: begin
                res_status_next = ST_NO_FREE;
            end
        endcase
    end

    // ---------------- state update ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAILBOXES; i++) begin
                mode_reg[i] <= MODE_OFF;
            end
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (mode_we) begin
                mode_reg[mode_widx] <= mode_wval;
            end
            if (work) begin
                rd_ptr_reg <= rd_ptr_next;
                wr_ptr_reg <= wr_ptr_next;
                fill_reg   <= fill_next;
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (advance) begin
            res_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (work) begin
            res_status_reg   <= res_status_next;
            res_mbox_reg     <= res_mbox_next;
            res_id_reg       <= res_id_next;
            res_payload_reg  <= res_payload_next;
            res_from_ram_reg <= res_from_ram_next;
            res_count_reg    <= COUNT_W'(fill_next);
        end
    end

    // Popped frames come straight from the RAM output register; it holds
    // while the result waits because the RAM reads only when the pipe moves.
    assign m_valid          = res_valid_reg;
    assign m_status         = res_status_reg;
    assign m_mailbox        = res_mbox_reg;
    assign m_out_id         = res_from_ram_reg ? ram_rdata[ENTRY_W-1:DATA_W] : res_id_reg;
    assign m_out_payload    = res_from_ram_reg ? ram_rdata[DATA_W-1:0] : res_payload_reg;
    assign m_frames_waiting = res_count_reg;

endmodule

/* rtl/core/cmm_rx_check.sv */
`include "can_mailbox_manager_rx_fifo_top_assert.svh"

module cmm_rx_check
    import cmm_rx_pkg::*;
#(
    parameter int FIFO_DEPTH = 8
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STATUS_W-1:0] m_status,
    input logic [MBOX_W-1:0]   m_mailbox,
    input logic [ID_W-1:0]     m_out_id,
    input logic [DATA_W-1:0]   m_out_payload,
    input logic [COUNT_W-1:0]  m_frames_waiting
);

    `CMM_ASSERT_NEXT(a_result_held, m_valid && !m_ready,
        m_valid && $stable(m_out_payload) && $stable(m_out_id) && $stable(m_status),
        "result changed while stalled")

    `CMM_ASSERT_NOW(a_count_bound, m_valid,
        (FIFO_DEPTH >= 16) || (m_frames_waiting <= FIFO_DEPTH),
        "frame count above FIFO depth")

    `CMM_ASSERT_NOW(a_read_empty, m_valid && m_status == ST_READ_EMPTY,
        m_frames_waiting == '0 && m_out_id == '0 && m_out_payload == '0,
        "empty read reported data or frames")

    `CMM_ASSERT_NOW(a_no_free, m_valid && m_status == ST_NO_FREE,
        m_mailbox == '0 && m_out_id == '0 && m_out_payload == '0,
        "no-free result carries data")

    `CMM_ASSERT_NOW(a_event_clean,
        m_valid && (m_status == ST_RX_QUEUED || m_status == ST_RX_DROPPED ||
                    m_status == ST_TX_RELEASED || m_status == ST_NO_FLAG),
        m_out_id == '0 && m_out_payload == '0,
        "event result carries identifier or data")

endmodule

bind can_mailbox_manager_rx_fifo_top cmm_rx_check #(.FIFO_DEPTH(FIFO_DEPTH)) u_check (.*);
